### hw/rtl/hfbd_pkg.sv
// Package with constants, types and floating-point helper functions for the 4x4 box downsampler.
`timescale 1ns / 1ps

package hfbd_pkg;

    localparam int MAX_OUT_SIDE_DEF = 1024;
    localparam int DST_W            = 11;
    localparam int HALF_W           = 16;
    localparam int FACE_W           = 3;
    localparam int NUM_FACES        = 6;
    localparam int BLOCK            = 4;
    localparam logic [DST_W-1:0] DST_RESET = 11'd256;

    localparam logic [31:0] FP_NAN   = 32'h7FC0_0000;
    localparam logic [15:0] HALF_NAN = 16'h7E00;
    localparam logic [15:0] HALF_INF = 16'h7C00;

    typedef logic [3:0][31:0] t_rgba;

    // Half bit pattern to single precision (exact).
    function automatic logic [31:0] half_to_float(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [9:0]  mn;
        logic [7:0]  fe;
        sgn = {h[15], 31'b0};
        e   = h[14:10];
        m   = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                p = 4'(i);
            end
        end
        mn = 10'(m << (4'd10 - p));
        fe = 8'd103 + 8'(p);
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                half_to_float = sgn;
            end else begin
                half_to_float = sgn | {1'b0, fe, mn, 13'b0};
            end
        end else if (e == 5'h1F) begin
            half_to_float = sgn | 32'h7F80_0000 | {9'b0, m, 13'b0};
        end else begin
            half_to_float = sgn | {1'b0, 8'(e) + 8'd112, m, 13'b0};
        end
    endfunction

    // Single-precision add, round to nearest even. Operands here are never subnormal.
    function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] a, b;
        logic        sa, sb, sub, g, rs, inc;
        logic [7:0]  ea, eb, d;
        logic [23:0] ma, mb;
        logic [27:0] ax, bx0, bsh, s;
        logic        st;
        logic [4:0]  lz;
        logic        found;
        logic signed [9:0] e;
        logic [24:0] mr;
        if (x[30:0] >= y[30:0]) begin
            a = x;
            b = y;
        end else begin
            a = y;
            b = x;
        end
        sa  = a[31];
        sb  = b[31];
        ea  = a[30:23];
        eb  = b[30:23];
        ma  = {ea != 8'd0, a[22:0]};
        mb  = {eb != 8'd0, b[22:0]};
        d   = ea - eb;
        sub = sa ^ sb;
        ax  = {1'b0, ma, 3'b0};
        bx0 = {1'b0, mb, 3'b0};
        if (d >= 8'd27) begin
            bsh = 28'd0;
            st  = |mb;
        end else begin
            bsh = bx0 >> d;
            st  = |(bx0 & ((28'd1 << d) - 28'd1));
        end
        bsh[0] = bsh[0] | st;
        s = sub ? (ax - bsh) : (ax + bsh);
        lz = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && s[i]) begin
                found = 1'b1;
                lz = 5'(26 - i);
            end
        end
        e = 10'(ea);
        if (s[27]) begin
            s = {1'b0, s[27:2], s[1] | s[0]};
            e = e + 10'sd1;
        end else begin
            s = s << lz;
            e = e - 10'(lz);
        end
        g   = s[2];
        rs  = s[1] | s[0];
        inc = g & (rs | s[3]);
        mr  = {1'b0, s[26:3]} + 25'(inc);
        if (mr[24]) begin
            e  = e + 10'sd1;
            mr = 25'h080_0000;
        end
        if (a[30:23] == 8'hFF) begin
            if (a[22:0] != 23'd0 || b[30:23] == 8'hFF && (b[22:0] != 23'd0 || sub)) begin
                fp_add = FP_NAN;
            end else begin
                fp_add = a;
            end
        end else if (eb == 8'd0) begin
            fp_add = (ea == 8'd0) ? {sa & sb, 31'b0} : a;
        end else if (s == 28'd0) begin
            fp_add = 32'd0;
        end else if (e >= 10'sd255) begin
            fp_add = {sa, 8'hFF, 23'd0};
        end else if (e <= 10'sd0) begin
            fp_add = {sa, 31'b0};
        end else begin
            fp_add = {sa, e[7:0], mr[22:0]};
        end
    endfunction

    // Divide a single-precision sum by 16 and round to half, nearest even.
    function automatic logic [15:0] sum_to_half_avg(input logic [31:0] f);
        logic [15:0] sgn;
        logic [7:0]  e;
        logic [22:0] m;
        logic signed [9:0] ue;
        logic [15:0] h;
        logic [12:0] rem13;
        logic [4:0]  sh;
        logic [23:0] full, hs, rem, halfbit;
        sgn  = {f[31], 15'b0};
        e    = f[30:23];
        m    = f[22:0];
        ue   = 10'(e) - 10'sd131;
        h    = 16'd0;
        rem13 = m[12:0];
        sh   = 5'(-ue - 10'sd1);
        full = {1'b1, m};
        hs   = full >> sh;
        rem  = full & ((24'd1 << sh) - 24'd1);
        halfbit = 24'd1 << (sh - 5'd1);
        if (e == 8'hFF) begin
            sum_to_half_avg = (m != 23'd0) ? HALF_NAN : (sgn | HALF_INF);
        end else if (e == 8'd0) begin
            sum_to_half_avg = sgn;
        end else if (ue > 10'sd15) begin
            sum_to_half_avg = sgn | HALF_INF;
        end else if (ue >= -10'sd14) begin
            h = sgn | {1'b0, 5'(ue + 10'sd15), m[22:13]};
            if (rem13 > 13'h1000 || (rem13 == 13'h1000 && h[0])) begin
                h = h + 16'd1;
            end
            sum_to_half_avg = h;
        end else if (-ue - 10'sd1 > 10'sd24) begin
            sum_to_half_avg = sgn;
        end else begin
            if (rem > halfbit || (rem == halfbit && hs[0])) begin
                hs = hs + 24'd1;
            end
            sum_to_half_avg = sgn | hs[15:0];
        end
    endfunction

endpackage

### hw/rtl/half_float_box_downsample_4x4_core.sv
// Top level of the half-float 4x4 box downsampler for six cube faces.
// A result is held in the stage-one registers, then in the result register, after its block's last pixel is taken.
// One source pixel per cycle unless a result waits at a stalled output; the running-sum adder is combinational.
// Column partial sums sit in a MAX_OUT_SIDE-deep line memory with registered read and bypass.
// Reset (synchronous, active low) clears counters, running sum and valid flags; size is 256.
`timescale 1ns / 1ps

module half_float_box_downsample_4x4_core #(
    parameter int MAX_OUT_SIDE = hfbd_pkg::MAX_OUT_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hfbd_pkg::DST_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hfbd_pkg::HALF_W-1:0]   i_in_red,
    input  logic [hfbd_pkg::HALF_W-1:0]   i_in_green,
    input  logic [hfbd_pkg::HALF_W-1:0]   i_in_blue,
    input  logic [hfbd_pkg::HALF_W-1:0]   i_in_alpha,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hfbd_pkg::HALF_W-1:0]   o_out_red,
    output logic [hfbd_pkg::HALF_W-1:0]   o_out_green,
    output logic [hfbd_pkg::HALF_W-1:0]   o_out_blue,
    output logic [hfbd_pkg::HALF_W-1:0]   o_out_alpha,
    output logic [hfbd_pkg::FACE_W-1:0]   o_face_index,
    output logic                          o_face_done
);
    import hfbd_pkg::*;

    localparam int CW    = $clog2(BLOCK * MAX_OUT_SIDE) < 2 ? 2 : $clog2(BLOCK * MAX_OUT_SIDE);
    localparam int SRC_W = $clog2(BLOCK * MAX_OUT_SIDE + 1);
    localparam int OX_W  = MAX_OUT_SIDE > 1 ? $clog2(MAX_OUT_SIDE) : 1;

    logic [DST_W-1:0]  r_dst_size;
    logic [CW-1:0]     r_col, r_row;
    logic [FACE_W-1:0] r_face;

    logic [SRC_W-1:0]  eff;
    logic [SRC_W-1:0]  src;
    logic [SRC_W-1:0]  col_x, row_x;
    logic              acc, adv, commit, out_free;
    logic [1:0]        xres, yres;
    logic [OX_W-1:0]   ox;
    logic              last_col, last_row;

    // Stage-one registers.
    logic              r_v1;
    logic [3:0][15:0]  r_px;
    logic              r_x0, r_xl, r_y0, r_yl;
    logic [OX_W-1:0]   r_ox;
    logic [FACE_W-1:0] r_f1;
    logic              r_fd1;
    t_rgba             r_rd, r_bypd, r_run;
    logic              r_byp;

    t_rgba             mem [MAX_OUT_SIDE];
    t_rgba             col_base, sums;
    logic              wr_en;

    // Result register.
    logic              r_ov;
    t_rgba             r_osum;
    logic [FACE_W-1:0] r_of;
    logic              r_ofd;

    always_comb begin
        if (r_dst_size == '0) begin
            eff = SRC_W'(1);
        end else if (32'(r_dst_size) > MAX_OUT_SIDE) begin
            eff = SRC_W'(MAX_OUT_SIDE);
        end else begin
            eff = SRC_W'(r_dst_size);
        end
    end

    assign src      = SRC_W'(eff << 2);
    assign col_x    = SRC_W'(r_col);
    assign row_x    = SRC_W'(r_row);
    assign xres     = r_col[1:0];
    assign yres     = r_row[1:0];
    assign ox       = OX_W'(r_col >> 2);
    assign last_col = (col_x == src - SRC_W'(1));
    assign last_row = (row_x == src - SRC_W'(1));

    assign out_free   = !r_ov || !i_out_stall;
    assign adv        = !r_v1 || out_free;
    assign o_in_stall = !adv;
    assign acc        = i_in_valid && adv;
    assign commit     = r_v1 && adv;
    assign wr_en      = commit && r_xl && !r_yl;

    always_comb begin
        col_base = r_byp ? r_bypd : r_rd;
        for (int c = 0; c < 4; c++) begin
            logic [31:0] base;
            if (!r_x0) begin
                base = r_run[c];
            end else if (!r_y0) begin
                base = col_base[c];
            end else begin
                base = 32'd0;
            end
            sums[c] = fp_add(base, half_to_float(r_px[c]));
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_size <= DST_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_face     <= '0;
            r_v1       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dst_size <= i_cfg_wdata;
                r_col      <= '0;
                r_row      <= '0;
                r_face     <= '0;
            end else if (acc) begin
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row  <= '0;
                        r_face <= (32'(r_face) == NUM_FACES - 1) ? '0 : r_face + FACE_W'(1);
                    end else begin
                        r_row <= r_row + CW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (acc) begin
                r_v1 <= 1'b1;
            end else if (adv) begin
                r_v1 <= 1'b0;
            end
            if (commit && r_xl && r_yl) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Running sum along a block row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_cfg_we) begin
            r_run <= '0;
        end else if (commit && !r_xl) begin
            r_run <= sums;
        end
    end

    // Stage-one payload, line memory read and write-to-read bypass.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_px  <= {i_in_alpha, i_in_blue, i_in_green, i_in_red};
            r_x0  <= (xres == 2'd0);
            r_xl  <= (xres == 2'd3);
            r_y0  <= (yres == 2'd0);
            r_yl  <= (yres == 2'd3);
            r_ox  <= ox;
            r_f1  <= r_face;
            r_fd1 <= last_col && last_row;
            r_rd  <= mem[ox];
            // A column sum written at this edge is the one the new transaction must read.
            r_byp  <= wr_en && (r_ox == ox);
            r_bypd <= sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_ox] <= sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && r_xl && r_yl) begin
            r_osum <= sums;
            r_of   <= r_f1;
            r_ofd  <= r_fd1;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_red    = sum_to_half_avg(r_osum[0]);
    assign o_out_green  = sum_to_half_avg(r_osum[1]);
    assign o_out_blue   = sum_to_half_avg(r_osum[2]);
    assign o_out_alpha  = sum_to_half_avg(r_osum[3]);
    assign o_face_index = r_of;
    assign o_face_done  = r_ofd;

endmodule
